[rtl/hof_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hof_pkg
// Shared types and constants of the hampel outlier filter: register codes,
// controller states and the command and status groups between the modules.
// ----------------------------------------------------------------------------
package hof_pkg;

    localparam int MIN_FILL       = 3;
    localparam int WINDOW_DEFAULT = 7;
    localparam int CHUNK_W        = 16;
    localparam int PROD_W         = 32;
    localparam int THR_FRAC       = 20;

    localparam logic [15:0] THRESHOLD_RESET = 16'd768;
    localparam logic [15:0] SCALE_RESET     = 16'd6073;

    typedef enum logic [1:0] {
        REG_ENABLE    = 2'd0,
        REG_WINDOW    = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_SCALE     = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SEL1,
        S_MED,
        S_LOAD2,
        S_SEL2,
        S_MAD,
        S_MUL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic load_vals;
        logic load_devs;
        logic sel_step;
        logic save_med;
        logic save_mad;
        logic mul_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic pass;
        logic last_cand;
        logic last_chunk;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

[rtl/hof_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hof_ctrl
// Filter sequencer: takes a sample, runs the two rank selections and the
// threshold product unless it passes through, then fills the output register.
// ----------------------------------------------------------------------------
module hof_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  hof_pkg::t_sts    i_sts,
    output hof_pkg::t_cmd    o_cmd
);

    hof_pkg::t_state r_state;
    hof_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hof_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hof_pkg::S_IDLE: begin
                if (i_valid) n_state = hof_pkg::S_START;
            end
            hof_pkg::S_START: begin
                n_state = i_sts.pass ? hof_pkg::S_EMIT : hof_pkg::S_SEL1;
            end
            hof_pkg::S_SEL1: begin
                if (i_sts.last_cand) n_state = hof_pkg::S_MED;
            end
            hof_pkg::S_MED:   n_state = hof_pkg::S_LOAD2;
            hof_pkg::S_LOAD2: n_state = hof_pkg::S_SEL2;
            hof_pkg::S_SEL2: begin
                if (i_sts.last_cand) n_state = hof_pkg::S_MAD;
            end
            hof_pkg::S_MAD: n_state = hof_pkg::S_MUL;
            hof_pkg::S_MUL: begin
                if (i_sts.last_chunk) n_state = hof_pkg::S_EMIT;
            end
            hof_pkg::S_EMIT: begin
                if (i_sts.out_free) n_state = hof_pkg::S_IDLE;
            end
            default: n_state = hof_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            hof_pkg::S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            hof_pkg::S_START: o_cmd.load_vals = !i_sts.pass;
            hof_pkg::S_SEL1:  o_cmd.sel_step  = 1'b1;
            hof_pkg::S_MED:   o_cmd.save_med  = 1'b1;
            hof_pkg::S_LOAD2: o_cmd.load_devs = 1'b1;
            hof_pkg::S_SEL2:  o_cmd.sel_step  = 1'b1;
            hof_pkg::S_MAD:   o_cmd.save_mad  = 1'b1;
            hof_pkg::S_MUL:   o_cmd.mul_step  = 1'b1;
            hof_pkg::S_EMIT:  o_cmd.emit      = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/hof_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hof_dp
// Datapath: sample ring, rank selector shared by the median and the MAD
// passes, chunked threshold multiply, outlier decision and output register.
// ----------------------------------------------------------------------------
module hof_dp #(
    parameter int WINDOW_MAX   = 11,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  hof_pkg::t_cmd                       i_cmd,
    output hof_pkg::t_sts                       o_sts,
    input  wire logic                           i_enable,
    input  wire logic [3:0]                     i_window_length,
    input  wire logic [15:0]                    i_threshold,
    input  wire logic [15:0]                    i_scale,
    input  wire logic                           i_restart,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample_out,
    output logic                                o_was_replaced
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int MW   = SW + 1;
    localparam int KW   = SW + 3;
    localparam int DEVW = SW + 2;
    localparam int MADW = SW + 3;
    localparam int NCH  = (MADW + hof_pkg::CHUNK_W - 1) / hof_pkg::CHUNK_W;
    localparam int MPAD = NCH * hof_pkg::CHUNK_W;
    localparam int AW   = hof_pkg::PROD_W + MPAD;
    localparam int IW   = $clog2(WINDOW_MAX);
    localparam int CNTW = $clog2(WINDOW_MAX + 1);
    localparam int CMPW = (CNTW > 4) ? CNTW : 4;
    localparam int CHW  = $clog2(NCH);

    logic signed [SW-1:0]   r_ring [WINDOW_MAX];
    logic [IW-1:0]          r_wp;
    logic [CNTW-1:0]        r_fill;
    logic [CNTW-1:0]        r_n;
    logic signed [SW-1:0]   r_sample;
    logic                   r_pass;
    logic signed [KW-1:0]   r_key [WINDOW_MAX];
    logic [IW-1:0]          r_cand;
    logic signed [KW-1:0]   r_lo;
    logic signed [KW-1:0]   r_hi;
    logic signed [MW-1:0]   r_med2;
    logic [DEVW-1:0]        r_dev4;
    logic [hof_pkg::PROD_W-1:0] r_prod;
    logic [MADW-1:0]        r_mad4;
    logic [MPAD-1:0]        r_madsh;
    logic [AW-1:0]          r_acc;
    logic [CHW-1:0]         r_chunk;
    logic                   r_out_valid;
    logic signed [SW-1:0]   r_out_sample;
    logic                   r_out_repl;

    logic [CMPW-1:0]        wlen_x;
    logic [CMPW-1:0]        wp_inc;
    logic [IW-1:0]          n_wp;
    logic [CNTW-1:0]        n_fill;
    logic signed [KW-1:0]   cand_val;
    logic [CNTW-1:0]        cnt_lt;
    logic [CNTW-1:0]        cnt_le;
    logic [CNTW-1:0]        k_lo;
    logic [CNTW-1:0]        k_hi;
    logic signed [KW:0]     pair_sum;
    logic signed [KW-1:0]   dev_key [WINDOW_MAX];
    logic signed [KW-1:0]   s_diff;
    logic signed [KW-1:0]   s_neg;
    logic [SW:0]            s_abs;
    logic [hof_pkg::PROD_W+hof_pkg::CHUNK_W-1:0] part;
    logic [AW-1:0]          lhs;
    logic                   replace;

    // ring pointer and fill count after this transfer
    always_comb begin
        wlen_x = CMPW'(i_window_length);
        wp_inc = CMPW'(r_wp) + CMPW'(1);
        if (wp_inc >= wlen_x || wp_inc >= CMPW'(WINDOW_MAX)) begin
            n_wp = '0;
        end else begin
            n_wp = wp_inc[IW-1:0];
        end
        if (CMPW'(r_fill) < wlen_x) begin
            n_fill = r_fill + CNTW'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    // rank test of one candidate against every filled key
    always_comb begin
        cand_val = r_key[r_cand];
        cnt_lt   = '0;
        cnt_le   = '0;
        for (int j = 0; j < WINDOW_MAX; j++) begin
            if (j < int'(r_n)) begin
                cnt_lt = cnt_lt + CNTW'(r_key[j] <  cand_val);
                cnt_le = cnt_le + CNTW'(r_key[j] <= cand_val);
            end
        end
        k_lo     = (r_n - CNTW'(1)) >> 1;
        k_hi     = r_n >> 1;
        pair_sum = {r_lo[KW-1], r_lo} + {r_hi[KW-1], r_hi};
    end

    // absolute deviations at double scale
    always_comb begin
        for (int j = 0; j < WINDOW_MAX; j++) begin
            logic signed [KW-1:0] d;
            d          = {{2{r_ring[j][SW-1]}}, r_ring[j], 1'b0}
                         - {{2{r_med2[MW-1]}}, r_med2};
            dev_key[j] = d[KW-1] ? -d : d;
        end
        s_diff = {{2{r_sample[SW-1]}}, r_sample, 1'b0} - {{2{r_med2[MW-1]}}, r_med2};
        s_neg  = -s_diff;
        s_abs  = s_diff[KW-1] ? s_neg[SW:0] : s_diff[SW:0];
    end

    always_comb begin
        part    = r_prod * r_madsh[MPAD-1 -: hof_pkg::CHUNK_W];
        lhs     = AW'({r_dev4, {hof_pkg::THR_FRAC{1'b0}}});
        replace = (r_mad4 != '0) && (lhs > r_acc);
    end

    always_comb begin
        o_sts.pass       = r_pass;
        o_sts.last_cand  = (CNTW'(r_cand) + CNTW'(1)) == r_n;
        o_sts.last_chunk = r_chunk == CHW'(NCH - 1);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_wp   <= '0;
                r_fill <= '0;
            end else if (i_cmd.accept && i_enable) begin
                r_wp   <= n_wp;
                r_fill <= n_fill;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample_in;
            r_n      <= n_fill;
            r_pass   <= !i_enable || (n_fill < CNTW'(hof_pkg::MIN_FILL));
            if (i_enable) r_ring[r_wp] <= i_sample_in;
        end
        if (i_cmd.load_vals) begin
            for (int j = 0; j < WINDOW_MAX; j++) begin
                r_key[j] <= KW'(r_ring[j]);
            end
            r_cand <= '0;
        end
        if (i_cmd.load_devs) begin
            r_key  <= dev_key;
            r_cand <= '0;
            r_dev4 <= {s_abs, 1'b0};
            r_prod <= i_threshold * i_scale;
        end
        if (i_cmd.sel_step) begin
            if (cnt_lt <= k_lo && k_lo < cnt_le) r_lo <= cand_val;
            if (cnt_lt <= k_hi && k_hi < cnt_le) r_hi <= cand_val;
            r_cand <= r_cand + IW'(1);
        end
        if (i_cmd.save_med) begin
            r_med2 <= pair_sum[MW-1:0];
        end
        if (i_cmd.save_mad) begin
            r_mad4  <= pair_sum[MADW-1:0];
            r_madsh <= MPAD'(pair_sum[MADW-1:0]);
            r_acc   <= '0;
            r_chunk <= '0;
        end
        // most significant chunk first
        if (i_cmd.mul_step) begin
            r_acc   <= (r_acc << hof_pkg::CHUNK_W) + AW'(part);
            r_madsh <= r_madsh << hof_pkg::CHUNK_W;
            r_chunk <= r_chunk + CHW'(1);
        end
        if (i_cmd.emit) begin
            if (!r_pass && replace) begin
                r_out_sample <= r_med2[MW-1:1];
                r_out_repl   <= 1'b1;
            end else begin
                r_out_sample <= r_sample;
                r_out_repl   <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_out   = r_out_sample;
    assign o_was_replaced = r_out_repl;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_fill) <= wlen_x)
        else $error("fill count beyond window length");

    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_wp) < wlen_x)
        else $error("write position outside window");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites a pending transfer");

    a_fill_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && i_enable && !i_restart && CMPW'(r_fill) < wlen_x)
        |=> r_fill == $past(r_fill) + CNTW'(1))
        else $error("fill count did not advance");

endmodule
`default_nettype wire

[rtl/hampel_outlier_filter_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hampel_outlier_filter_unit
// Hampel filter over a sliding sample ring with an APB register port.
// ----------------------------------------------------------------------------
// One sample is taken at a time and its result lands in an output register,
// so the next sample is taken while that result waits. A sample that passes
// straight through (filter off, or fewer than three samples in the ring)
// goes from the start state straight to the output. A filtered sample runs
// a median pass and a MAD pass over the ring fill (up to the window length),
// then the threshold multiply as NCH = ceil((SAMPLE_WIDTH+3)/16) partial
// products of 32x16. The rank selector tests one candidate per cycle in each
// of the median and MAD passes. Writing the window length restarts the ring.
// ----------------------------------------------------------------------------
module hampel_outlier_filter_unit #(
    parameter int WINDOW_MAX   = 11,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample_out,
    output logic                                o_was_replaced,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [3:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam logic [3:0] DEF_WINDOW = 4'((hof_pkg::WINDOW_DEFAULT < WINDOW_MAX)
                                          ? hof_pkg::WINDOW_DEFAULT : WINDOW_MAX);

    logic                r_enable;
    logic [3:0]          r_wlen;
    logic [15:0]         r_thr;
    logic [15:0]         r_scale;
    logic                wr;
    logic                restart;
    logic [3:0]          wlen_new;
    hof_pkg::t_reg_idx   idx;
    hof_pkg::t_cmd       cmd;
    hof_pkg::t_sts       sts;

    assign pready  = 1'b1;
    assign idx     = hof_pkg::t_reg_idx'(paddr[3:2]);
    assign wr      = psel && penable && pwrite;
    assign restart = wr && (idx == hof_pkg::REG_WINDOW);

    // out-of-range lengths fall back to the default
    always_comb begin
        if (int'(pwdata[3:0]) < hof_pkg::MIN_FILL || int'(pwdata[3:0]) > WINDOW_MAX) begin
            wlen_new = DEF_WINDOW;
        end else begin
            wlen_new = pwdata[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_wlen   <= DEF_WINDOW;
            r_thr    <= hof_pkg::THRESHOLD_RESET;
            r_scale  <= hof_pkg::SCALE_RESET;
        end else if (wr) begin
            case (idx)
                hof_pkg::REG_ENABLE:    r_enable <= pwdata[0];
                hof_pkg::REG_WINDOW:    r_wlen   <= wlen_new;
                hof_pkg::REG_THRESHOLD: r_thr    <= pwdata[15:0];
                hof_pkg::REG_SCALE:     r_scale  <= pwdata[15:0];
                default: r_enable <= r_enable;
            endcase
        end
    end

    always_comb begin
        case (idx)
            hof_pkg::REG_ENABLE:    prdata = 32'(r_enable);
            hof_pkg::REG_WINDOW:    prdata = 32'(r_wlen);
            hof_pkg::REG_THRESHOLD: prdata = 32'(r_thr);
            hof_pkg::REG_SCALE:     prdata = 32'(r_scale);
            default:                prdata = '0;
        endcase
    end

    hof_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    hof_dp #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_enable        (r_enable),
        .i_window_length (r_wlen),
        .i_threshold     (r_thr),
        .i_scale         (r_scale),
        .i_restart       (restart),
        .i_sample_in     (i_sample_in),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_sample_out    (o_sample_out),
        .o_was_replaced  (o_was_replaced)
    );

endmodule
`default_nettype wire
